// File: rtl/ida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ida_pkg: shared types, constants and table builder for the degree angle unit
// Holds the per-item control word that moves down the search pipeline, the
// output angle codes, and the elaboration-time tangent table generator.
// ----------------------------------------------------------------------------
package ida_pkg;

  // Width of the in-quadrant angle accumulator (0..89 fits in seven bits).
  localparam int ACC_W = 7;
  // Number of table slots addressed by the accumulator.
  localparam int ACC_SPAN = 1 << ACC_W;
  // Largest in-quadrant angle.
  localparam logic [ACC_W-1:0] ANGLE_MAX = 7'd89;
  // Integer bits of a tangent entry; tan(89/57) is about 106.5.
  localparam int TAN_INT_BITS = 7;

  // Output angle width and the bus width it is padded to.
  localparam int OUT_W = 10;
  localparam int OUT_TDATA_W = 16;

  // Output codes, two's complement on OUT_W bits.
  localparam logic [OUT_W-1:0] ANG_NONE  = 10'h3FF;  // equal points, -1
  localparam logic [OUT_W-1:0] ANG_ZERO  = 10'd0;
  localparam logic [OUT_W-1:0] ANG_UP    = 10'd90;
  localparam logic [OUT_W-1:0] ANG_LEFT  = 10'd180;
  localparam logic [OUT_W-1:0] ANG_DOWN  = 10'd270;
  localparam logic [OUT_W-1:0] ANG_FULL  = 10'd360;

  // Geometric class of a point pair.
  typedef enum logic [1:0] {
    KIND_SAME = 2'd0,  // both points coincide
    KIND_VERT = 2'd1,  // no horizontal offset
    KIND_HORZ = 2'd2,  // no vertical offset
    KIND_DIAG = 2'd3   // both offsets nonzero, needs the table search
  } ida_kind_e;

  // Control word carried alongside the magnitudes through every stage.
  typedef struct packed {
    ida_kind_e        kind;
    logic             dx_neg;
    logic             dy_neg;
    logic [ACC_W-1:0] acc;
  } ida_ctl_t;

  // Bits 125:62 of the full 128-bit product, a Q62 multiply.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Restoring unsigned division, used only while building constants.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int i;
    rem = '0;
    quo = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Rounded tan(k/57) scaled by 2^frac_bits, from Q62 sine and cosine series.
  function automatic logic [63:0] tan_entry(input int k, input int frac_bits);
    logic [63:0] one;
    logic [63:0] kk;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] term;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] n;
    logic        done;
    int          i;
    one = 64'd1 << 62;
    kk = 64'(k);
    x = kk * (one / 64'd57) + (kk * (one % 64'd57)) / 64'd57;
    x2 = mul_q62(x, x);
    s = x;
    c = one;
    // Sine series.
    term = x;
    done = 1'b0;
    for (n = 64'd1; n < 64'd40; n++) begin
      if (!done) begin
        term = udiv64(mul_q62(term, x2), (64'd2 * n) * (64'd2 * n + 64'd1));
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (n[0]) begin
          s = s - term;
        end else begin
          s = s + term;
        end
      end
    end
    // Cosine series.
    term = one;
    done = 1'b0;
    for (n = 64'd1; n < 64'd40; n++) begin
      if (!done) begin
        term = udiv64(mul_q62(term, x2), (64'd2 * n - 64'd1) * (64'd2 * n));
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (n[0]) begin
          c = c - term;
        end else begin
          c = c + term;
        end
      end
    end
    if (c == 64'd0) begin
      return 64'd0;
    end
    // Quotient with one extra fraction bit, then round half up.
    q = udiv64(s, c);
    r = s - q * c;
    for (i = 0; i <= frac_bits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= c) begin
        r = r - c;
        q = q | 64'd1;
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

endpackage

// File: rtl/integer_degree_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_degree_angle: direction between two points in whole degrees
// Stream-in point pairs, stream-out the angle from the first to the second.
// ----------------------------------------------------------------------------
// The unit accepts one point pair per clock while the output is not stalled:
// the offsets are formed and the pair classified as it is loaded into the
// entry register, one search stage per angle bit runs a binary search over a
// constant tangent table (one multiply and compare per stage, one bit of the
// angle each), and the quadrant is mapped into the output register. With y
// growing downward, equal points give -1, a vertical pair 90 or 270, a
// horizontal pair 0 or 180, and any other pair the quadrant-mapped value of
// trunc(atan(|dy|/|dx|) * 57) in 0..89, so 360 appears for shallow pairs
// going down and to the right. Every stage holds its item under
// back-pressure, and empty stages close up, so nothing is lost.
// ----------------------------------------------------------------------------
module integer_degree_angle
  import ida_pkg::*;
#(
  parameter int COORD_BITS    = 12,
  parameter int TAN_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream; tdata from bit 0: from_x, from_y, to_x, to_y, zero padding.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // Output stream; tdata from bit 0: angle_deg (10-bit signed), zero padding.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [OUT_TDATA_W-1:0]       m_axis_tdata
);

  localparam int NSTEP = ACC_W;
  localparam int C     = COORD_BITS;

  logic [C-1:0] from_x;
  logic [C-1:0] from_y;
  logic [C-1:0] to_x;
  logic [C-1:0] to_y;
  logic         dx_neg;
  logic         dy_neg;
  logic [C-1:0] adx;
  logic [C-1:0] ady;
  ida_ctl_t     ctl_in;

  logic         st_vld   [NSTEP+1];
  logic         st_ready [NSTEP+2];
  ida_ctl_t     st_ctl   [NSTEP+1];
  logic [C-1:0] st_adx   [NSTEP+1];
  logic [C-1:0] st_ady   [NSTEP+1];

  logic             v0_q;
  ida_ctl_t         ctl0_q;
  logic [C-1:0]     adx0_q;
  logic [C-1:0]     ady0_q;
  logic [OUT_W-1:0] acc_ext;
  logic [OUT_W-1:0] angle_d;
  logic [OUT_W-1:0] angle_q;
  logic             out_vld_q;
  logic             s_fire;

  // Field unpacking.
  assign from_x = s_axis_tdata[C-1:0];
  assign from_y = s_axis_tdata[2*C-1:C];
  assign to_x   = s_axis_tdata[3*C-1:2*C];
  assign to_y   = s_axis_tdata[4*C-1:3*C];

  // Offset magnitudes, signs and the class of the pair.
  always_comb begin
    dx_neg = from_x > to_x;
    dy_neg = from_y > to_y;
    adx    = dx_neg ? (from_x - to_x) : (to_x - from_x);
    ady    = dy_neg ? (from_y - to_y) : (to_y - from_y);
    ctl_in.dx_neg = dx_neg;
    ctl_in.dy_neg = dy_neg;
    ctl_in.acc    = '0;
    if (adx == '0 && ady == '0) begin
      ctl_in.kind = KIND_SAME;
    end else if (adx == '0) begin
      ctl_in.kind = KIND_VERT;
    end else if (ady == '0) begin
      ctl_in.kind = KIND_HORZ;
    end else begin
      ctl_in.kind = KIND_DIAG;
    end
  end

  // Entry stage register.
  assign st_ready[0]   = ~v0_q | st_ready[1];
  assign s_axis_tready = st_ready[0];
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (st_ready[0]) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      ctl0_q <= ctl_in;
      adx0_q <= adx;
      ady0_q <= ady;
    end
  end

  assign st_vld[0] = v0_q;
  assign st_ctl[0] = ctl0_q;
  assign st_adx[0] = adx0_q;
  assign st_ady[0] = ady0_q;

  // Binary search, most significant angle bit first.
  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    ida_search_stage #(
      .COORD_BITS   (COORD_BITS),
      .TAN_FRAC_BITS(TAN_FRAC_BITS),
      .STEP_BIT     (NSTEP - 1 - g)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(st_vld[g]),
      .ready_o(st_ready[g+1]),
      .ctl_i  (st_ctl[g]),
      .adx_i  (st_adx[g]),
      .ady_i  (st_ady[g]),
      .valid_o(st_vld[g+1]),
      .ready_i(st_ready[g+2]),
      .ctl_o  (st_ctl[g+1]),
      .adx_o  (st_adx[g+1]),
      .ady_o  (st_ady[g+1])
    );
  end

  // Quadrant mapping of the searched angle.
  assign acc_ext = OUT_W'(st_ctl[NSTEP].acc);

  always_comb begin
    case (st_ctl[NSTEP].kind)
      KIND_SAME: angle_d = ANG_NONE;
      KIND_VERT: angle_d = st_ctl[NSTEP].dy_neg ? ANG_UP : ANG_DOWN;
      KIND_HORZ: angle_d = st_ctl[NSTEP].dx_neg ? ANG_LEFT : ANG_ZERO;
      KIND_DIAG: begin
        if (!st_ctl[NSTEP].dx_neg && st_ctl[NSTEP].dy_neg) begin
          angle_d = acc_ext;
        end else if (st_ctl[NSTEP].dx_neg && st_ctl[NSTEP].dy_neg) begin
          angle_d = ANG_LEFT - acc_ext;
        end else if (!st_ctl[NSTEP].dx_neg) begin
          angle_d = ANG_FULL - acc_ext;
        end else begin
          angle_d = ANG_LEFT + acc_ext;
        end
      end
      default: angle_d = ANG_NONE;
    endcase
  end

  // Output register.
  assign st_ready[NSTEP+1] = ~out_vld_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (st_ready[NSTEP+1]) begin
      out_vld_q <= st_vld[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_ready[NSTEP+1] && st_vld[NSTEP]) begin
      angle_q <= angle_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, angle_q};

  // An accepted input always lands in the entry stage.
  a_entry_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> v0_q)
    else $error("accepted input did not reach the entry stage");

  // An empty entry stage must never push back on the input.
  a_entry_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v0_q |-> s_axis_tready)
    else $error("input stalled while the entry stage was empty");

  // The finished search never yields an angle beyond the table.
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_vld[NSTEP] |-> (st_ctl[NSTEP].acc <= ANGLE_MAX))
    else $error("search produced an angle above the last table entry");

  // Delivered angles are -1 or within 0..360.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (angle_q == ANG_NONE || angle_q <= ANG_FULL))
    else $error("output angle out of range");

  // A stalled output holds its angle while the pipeline behind it waits.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(angle_q))
    else $error("output angle changed under back-pressure");

endmodule

// File: rtl/ida_search_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ida_search_stage: one step of the tangent table binary search
// Tries to set one bit of the in-quadrant angle: the bit stays when the
// candidate angle is in range and |dy| * 2^F >= |dx| * tan(candidate) * 2^F.
// ----------------------------------------------------------------------------
module ida_search_stage
  import ida_pkg::*;
#(
  parameter int COORD_BITS    = 12,
  parameter int TAN_FRAC_BITS = 16,
  parameter int STEP_BIT      = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Upstream side.
  input  logic                  valid_i,
  output logic                  ready_o,
  input  ida_ctl_t              ctl_i,
  input  logic [COORD_BITS-1:0] adx_i,
  input  logic [COORD_BITS-1:0] ady_i,
  // Downstream side.
  output logic                  valid_o,
  input  logic                  ready_i,
  output ida_ctl_t              ctl_o,
  output logic [COORD_BITS-1:0] adx_o,
  output logic [COORD_BITS-1:0] ady_o
);

  localparam int TW = TAN_FRAC_BITS + TAN_INT_BITS;
  localparam int PW = COORD_BITS + TW;

  logic [TW-1:0]    tan_tbl [ACC_SPAN];
  logic [ACC_W-1:0] step_mask;
  logic [ACC_W-1:0] cand;
  logic [PW-1:0]    lhs;
  logic [PW-1:0]    rhs;
  logic             take;
  logic             valid_q;
  ida_ctl_t         ctl_q;
  ida_ctl_t         ctl_d;
  logic [COORD_BITS-1:0] adx_q;
  logic [COORD_BITS-1:0] ady_q;

  // Constant tangent table; slot zero and slots past the last angle are unused.
  for (genvar k = 0; k < ACC_SPAN; k++) begin : g_tan
    localparam logic [63:0] TAN_K =
      (k >= 1 && k <= int'(ANGLE_MAX)) ? tan_entry(k, TAN_FRAC_BITS) : 64'd0;
    assign tan_tbl[k] = TAN_K[TW-1:0];
  end

  // Candidate angle and the multiply-compare against its tangent.
  assign step_mask = ACC_W'(1) << STEP_BIT;
  assign cand      = ctl_i.acc | step_mask;
  assign lhs       = {{TAN_INT_BITS{1'b0}}, ady_i, {TAN_FRAC_BITS{1'b0}}};
  assign rhs       = PW'(adx_i) * PW'(tan_tbl[cand]);
  assign take      = (cand <= ANGLE_MAX) && (lhs >= rhs);

  always_comb begin
    ctl_d = ctl_i;
    if (take) begin
      ctl_d.acc = cand;
    end
  end

  // The stage register loads whenever it is empty or its content moves on.
  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctl_q <= ctl_d;
      adx_q <= adx_i;
      ady_q <= ady_i;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign adx_o   = adx_q;
  assign ady_o   = ady_q;

endmodule
